// File: hdl/assert_macros.svh
// assertion macros shared by the encoder rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DFHE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dfhe assertion failed");

// antecedent at one edge implies consequent at the next
`define DFHE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dfhe assertion failed");

`endif

// File: hdl/dfhe_pkg.sv
// shared types and constants for the deflate fixed huffman symbol encoder
// no dependencies
`timescale 1ns / 1ps

package dfhe_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned ValueW = 16;
  localparam int unsigned CodeW  = 9;
  localparam int unsigned LenW   = 4;
  localparam int unsigned ExtraW = 13;

  localparam logic [ModeW-1:0] MODE_LIT  = 2'd0;
  localparam logic [ModeW-1:0] MODE_LEN  = 2'd1;
  localparam logic [ModeW-1:0] MODE_DIST = 2'd2;
  localparam logic [ModeW-1:0] MODE_EOB  = 2'd3;

  localparam logic [LenW-1:0] CLEN_DIST = 4'd5;
  localparam logic [LenW-1:0] CLEN_7    = 4'd7;
  localparam logic [LenW-1:0] CLEN_8    = 4'd8;
  localparam logic [LenW-1:0] CLEN_9    = 4'd9;

  typedef struct packed {
    logic [CodeW-1:0]  huff_code;
    logic [LenW-1:0]   huff_len;
    logic [ExtraW-1:0] extra_value;
    logic [LenW-1:0]   extra_len;
    logic              invalid;
  } dfhe_result_t;

endpackage

// File: hdl/dfhe_encode.sv
// symbol mapping logic: literal, length, distance and end of block
// depends on dfhe_pkg
`timescale 1ns / 1ps

module dfhe_encode (
  input  logic [dfhe_pkg::ModeW-1:0]  mode_i,
  input  logic [dfhe_pkg::ValueW-1:0] value_i,
  output dfhe_pkg::dfhe_result_t      result_o
);
  import dfhe_pkg::*;

  function automatic logic [2:0] top_bit8(input logic [7:0] x);
    logic [2:0] b;
    b = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (x[i]) b = 3'(i);
    end
    return b;
  endfunction

  function automatic logic [3:0] top_bit15(input logic [14:0] x);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 1; i < 15; i++) begin
      if (x[i]) b = 4'(i);
    end
    return b;
  endfunction

  // length path
  logic [8:0] lx9;
  logic [7:0] lx;
  logic [2:0] lb;
  logic [2:0] lelen;
  logic [7:0] lshift;
  logic [8:0] lsym_ext;
  logic [8:0] lsym;
  logic [7:0] lev;
  // distance path
  logic [15:0] dx16;
  logic [14:0] dx;
  logic [3:0]  db;
  logic [3:0]  delen;
  logic [14:0] dshift;
  logic [4:0]  dcode;
  logic [14:0] dev;

  always_comb begin
    lx9      = value_i[8:0] - 9'd3;
    lx       = lx9[7:0];
    lb       = top_bit8(lx);
    lelen    = lb - 3'd2;
    lshift   = lx >> lelen;
    lsym_ext = 9'd257 + {4'd0, lb - 3'd1, 2'b00} + {7'd0, lshift[1:0]};
    lev      = lx & ((8'd1 << lelen) - 8'd1);
    if (value_i == 16'd258) begin
      lsym = 9'd285;
    end else if (value_i <= 16'd10) begin
      lsym = 9'd254 + value_i[8:0];
    end else begin
      lsym = lsym_ext;
    end

    dx16   = value_i - 16'd1;
    dx     = dx16[14:0];
    db     = top_bit15(dx);
    delen  = db - 4'd1;
    dshift = dx >> delen;
    dcode  = {db, 1'b0} + {4'd0, dshift[0]};
    dev    = dx & ((15'd1 << delen) - 15'd1);
  end

  always_comb begin
    result_o = '0;
    case (mode_i)
      MODE_LIT: begin
        if (value_i > 16'd255) begin
          result_o.invalid = 1'b1;
        end else if (value_i < 16'd144) begin
          result_o.huff_code = 9'd48 + value_i[8:0];
          result_o.huff_len  = CLEN_8;
        end else begin
          // 400 + (v - 144) is v + 256
          result_o.huff_code = {1'b1, value_i[7:0]};
          result_o.huff_len  = CLEN_9;
        end
      end
      MODE_LEN: begin
        if (value_i < 16'd3 || value_i > 16'd258) begin
          result_o.invalid = 1'b1;
        end else begin
          if (value_i > 16'd10 && value_i != 16'd258) begin
            result_o.extra_len   = {1'b0, lelen};
            result_o.extra_value = {5'd0, lev};
          end
          if (lsym < 9'd280) begin
            result_o.huff_code = lsym - 9'd256;
            result_o.huff_len  = CLEN_7;
          end else begin
            result_o.huff_code = lsym - 9'd88;
            result_o.huff_len  = CLEN_8;
          end
        end
      end
      MODE_DIST: begin
        if (value_i < 16'd1 || value_i > 16'd32768) begin
          result_o.invalid = 1'b1;
        end else begin
          result_o.huff_len = CLEN_DIST;
          if (dx < 15'd4) begin
            result_o.huff_code = {7'd0, dx[1:0]};
          end else begin
            result_o.huff_code   = {4'd0, dcode};
            result_o.extra_len   = delen;
            result_o.extra_value = dev[12:0];
          end
        end
      end
      MODE_EOB: begin
        result_o.huff_len = CLEN_7;
      end
      default: begin
        result_o.invalid = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/deflate_fixed_huffman_symbol_encoder.sv
// channel   dir  handshake              payload
// request   in   in_valid_i/in_stall_o   mode_i, value_i
// symbol    out  out_valid_o/out_stall_i huff_code_o, huff_len_o, extra_*_o, invalid_o
//
// one request per cycle sustained while out_stall_i stays low; the accepting
// edge loads the request register, and the mapped result is then loaded into
// the result register, which drives the symbol outputs
// rst_ni clears both valid flags at once; payload registers are not reset
// a stalled symbol holds while one more request is still taken into the
// request register; in_stall_o rises only when both stages are full
// depends on dfhe_pkg, dfhe_encode and assert_macros.svh
`timescale 1ns / 1ps

module deflate_fixed_huffman_symbol_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dfhe_pkg::ModeW-1:0]    mode_i,
  input  logic [dfhe_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfhe_pkg::CodeW-1:0]    huff_code_o,
  output logic [dfhe_pkg::LenW-1:0]     huff_len_o,
  output logic [dfhe_pkg::ExtraW-1:0]   extra_value_o,
  output logic [dfhe_pkg::LenW-1:0]     extra_len_o,
  output logic                          invalid_o
);
  import dfhe_pkg::*;
  `include "assert_macros.svh"

  logic              s1_valid_q, s1_valid_d;
  logic [ModeW-1:0]  mode_q;
  logic [ValueW-1:0] value_q;
  logic              out_valid_q, out_valid_d;
  dfhe_result_t      res_d, res_q;
  logic              out_free;
  logic              s1_free;
  logic              in_take;

  dfhe_encode u_encode (
    .mode_i   (mode_q),
    .value_i  (value_q),
    .result_o (res_d)
  );

  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    s1_free     = !s1_valid_q || out_free;
    in_stall_o  = !s1_free;
    in_take     = in_valid_i && s1_free;
    s1_valid_d  = s1_free ? in_valid_i : s1_valid_q;
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (out_free && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign huff_code_o   = res_q.huff_code;
  assign huff_len_o    = res_q.huff_len;
  assign extra_value_o = res_q.extra_value;
  assign extra_len_o   = res_q.extra_len;
  assign invalid_o     = res_q.invalid;

  // stall only with both stages full and the symbol held
  `DFHE_ASSERT(a_stall_full, !in_stall_o || (s1_valid_q && out_valid_q && out_stall_i))
  // a request in the first stage moves on when the result register frees
  `DFHE_ASSERT_NEXT(a_advance, s1_valid_q && out_free, out_valid_q)
  // a flagged symbol carries no code and no extra bits
  `DFHE_ASSERT(a_invalid_empty,
    !(out_valid_q && res_q.invalid) || (res_q.huff_len == '0 && res_q.extra_len == '0))
  // a good symbol always has a code of at least five bits
  `DFHE_ASSERT(a_code_len, !(out_valid_q && !res_q.invalid) || (res_q.huff_len >= CLEN_DIST))

endmodule

// File: test/tb_deflate_fixed_huffman_symbol_encoder.sv
// testbench for the deflate fixed huffman symbol encoder: directed edge cases,
// well-formed and noisy random symbol requests, and random gaps and stalls on
// both sides; depends on dfhe_pkg and the encoder rtl
`timescale 1ns / 1ps

module tb_deflate_fixed_huffman_symbol_encoder;
  import dfhe_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ModeW-1:0]  mode_i;
  logic [ValueW-1:0] value_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CodeW-1:0]  huff_code_o;
  logic [LenW-1:0]   huff_len_o;
  logic [ExtraW-1:0] extra_value_o;
  logic [LenW-1:0]   extra_len_o;
  logic              invalid_o;

  dfhe_result_t expected_symbols[$];
  int           mismatches = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;

  deflate_fixed_huffman_symbol_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .huff_code_o   (huff_code_o),
    .huff_len_o    (huff_len_o),
    .extra_value_o (extra_value_o),
    .extra_len_o   (extra_len_o),
    .invalid_o     (invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned highest_bit(input int unsigned x);
    int unsigned b;
    b = 0;
    while (b < 31 && (x >> (b + 1)) != 0) b++;
    return b;
  endfunction

  // expected symbol for one request
  function automatic dfhe_result_t encode_symbol(input logic [ModeW-1:0] mode,
                                                 input logic [ValueW-1:0] value);
    dfhe_result_t r;
    int unsigned  v, x, b, sym, elen;
    r = '0;
    v = value;
    case (mode)
      MODE_LIT: begin
        if (v > 255) r.invalid = 1'b1;
        else if (v < 144) begin
          r.huff_code = CodeW'(48 + v);
          r.huff_len  = CLEN_8;
        end else begin
          r.huff_code = CodeW'(400 + (v - 144));
          r.huff_len  = CLEN_9;
        end
      end
      MODE_LEN: begin
        if (v < 3 || v > 258) r.invalid = 1'b1;
        else begin
          if (v == 258) sym = 285;
          else if (v <= 10) sym = 254 + v;
          else begin
            x    = v - 3;
            b    = highest_bit(x);
            elen = b - 2;
            sym  = 257 + 4 * (b - 1) + ((x >> elen) & 3);
            r.extra_len   = LenW'(elen);
            r.extra_value = ExtraW'(x & ((1 << elen) - 1));
          end
          if (sym < 280) begin
            r.huff_code = CodeW'(sym - 256);
            r.huff_len  = CLEN_7;
          end else begin
            r.huff_code = CodeW'(192 + (sym - 280));
            r.huff_len  = CLEN_8;
          end
        end
      end
      MODE_DIST: begin
        if (v < 1 || v > 32768) r.invalid = 1'b1;
        else begin
          x = v - 1;
          r.huff_len = CLEN_DIST;
          if (x < 4) r.huff_code = CodeW'(x);
          else begin
            b    = highest_bit(x);
            elen = b - 1;
            r.huff_code   = CodeW'(2 * b + ((x >> elen) & 1));
            r.extra_len   = LenW'(elen);
            r.extra_value = ExtraW'(x & ((1 << elen) - 1));
          end
        end
      end
      default: begin
        r.huff_len = CLEN_7;
      end
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // record accepted requests and check each symbol against the oldest one
  always @(posedge clk_i) begin
    dfhe_result_t want, got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_symbols.push_back(encode_symbol(mode_i, value_i));
      if (out_valid_o && !out_stall_i) begin
        got = '{huff_code_o, huff_len_o, extra_value_o, extra_len_o, invalid_o};
        if (expected_symbols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected symbol code=%0d len=%0d extra=%0d/%0d invalid=%0b",
                     got.huff_code, got.huff_len, got.extra_value, got.extra_len,
                     got.invalid);
        end else begin
          want = expected_symbols.pop_front();
          if (got.huff_code !== want.huff_code || got.huff_len !== want.huff_len ||
              got.extra_value !== want.extra_value || got.extra_len !== want.extra_len ||
              got.invalid !== want.invalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected code=%0d len=%0d extra=%0d/%0d invalid=%0b, %s",
                       want.huff_code, want.huff_len, want.extra_value, want.extra_len,
                       want.invalid,
                       $sformatf("got code=%0d len=%0d extra=%0d/%0d invalid=%0b",
                                 got.huff_code, got.huff_len, got.extra_value,
                                 got.extra_len, got.invalid));
          end
        end
      end
    end
  end

  task automatic send_request(input logic [ModeW-1:0] mode, input int unsigned value);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= ValueW'(value);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_literals();
    send_request(MODE_LIT, 0);
    send_request(MODE_LIT, 143);
    send_request(MODE_LIT, 144);
    send_request(MODE_LIT, 255);
    send_request(MODE_LIT, 256);
    send_request(MODE_LIT, 16'hFFFF);
  endtask

  task automatic test_lengths();
    send_request(MODE_LEN, 2);
    send_request(MODE_LEN, 3);
    send_request(MODE_LEN, 10);
    send_request(MODE_LEN, 11);
    send_request(MODE_LEN, 226);
    send_request(MODE_LEN, 227);
    send_request(MODE_LEN, 258);
    send_request(MODE_LEN, 259);
  endtask

  // includes the distances 5 and 8 and the 4097 and 24577 code boundaries
  task automatic test_distances();
    send_request(MODE_DIST, 0);
    send_request(MODE_DIST, 1);
    send_request(MODE_DIST, 4);
    send_request(MODE_DIST, 5);
    send_request(MODE_DIST, 8);
    send_request(MODE_DIST, 4097);
    send_request(MODE_DIST, 24577);
    send_request(MODE_DIST, 32768);
    send_request(MODE_DIST, 32769);
  endtask

  task automatic test_end_of_block();
    send_request(MODE_EOB, 16'hFFFF);
  endtask

  task automatic send_random_symbol();
    int unsigned r, b, v;
    r = $urandom_range(0, 99);
    if (r < 25) send_request(MODE_LIT, $urandom_range(0, 255));
    else if (r < 50) begin
      if ($urandom_range(0, 3) == 0) send_request(MODE_LEN, $urandom_range(3, 10));
      else send_request(MODE_LEN, $urandom_range(3, 258));
    end else if (r < 78) begin
      // spread over every distance code
      b = $urandom_range(1, 14);
      if (b == 1) v = $urandom_range(1, 4);
      else v = $urandom_range((1 << b) + 1, 1 << (b + 1));
      send_request(MODE_DIST, v);
    end else if (r < 84) send_request(MODE_EOB, $urandom_range(0, 65535));
    else send_request(ModeW'($urandom_range(0, 3)), $urandom_range(0, 65535));
  endtask

  task automatic test_random_symbols(input int count);
    repeat (count) send_random_symbol();
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_random_symbol();
    idle_on = 1'b1;
  endtask

  // sender holds off until every symbol has come back, then resumes
  task automatic test_drain_pause(input int count);
    repeat (4) begin
      repeat (count) send_random_symbol();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = MODE_LIT;
    value_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_literals();
    test_lengths();
    test_distances();
    test_end_of_block();
    test_random_symbols(1500);
    test_back_to_back(200);
    test_drain_pause(60);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_symbols.size() == 0) begin
      $display("tb_deflate_fixed_huffman_symbol_encoder OK");
    end else begin
      $display("tb_deflate_fixed_huffman_symbol_encoder NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_deflate_fixed_huffman_symbol_encoder NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dfhe_pkg.sv
hdl/dfhe_encode.sv
hdl/deflate_fixed_huffman_symbol_encoder.sv
test/tb_deflate_fixed_huffman_symbol_encoder.sv
